/* sv/dct_pkg.sv */
// Package for the daisy-chain topology table: sizes, id codes, operation codes
// and the request/result payload structs. No dependencies.
package dct_pkg;

  localparam int ID_W       = 6;                 // module id width
  localparam int DEPTH      = 64;                // table entries
  localparam int IDX_W      = $clog2(DEPTH);     // table / chain index width
  localparam int CNT_W      = $clog2(DEPTH + 1); // chain length width
  localparam int CIDX_W     = 6;                 // chain_index field width

  localparam logic [ID_W-1:0] ROOT_ID = ID_W'(0);
  localparam logic [ID_W-1:0] ID_NONE = ID_W'(63);  // downstream not known

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ID_W-1:0]   module_id;
    logic [ID_W-1:0]   downstream_id;
    logic [CIDX_W-1:0] chain_index;
  } dct_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]  chain_length;
    logic              length_changed;
    logic [ID_W-1:0]   read_id;
    logic              read_valid;
  } dct_out_t;

endpackage

/* sv/daisy_chain_topology_table.sv */
// Daisy-chain topology table: top level with the control sequencer.
// Depends on dct_pkg and two dct_ram instances (link table, chain store).
//
// The block keeps one entry per module id: a valid bit (flip-flops) and the
// downstream id (link RAM). A report request writes the entry; when the new
// downstream id is unknown and the old one was not, the old downstream entry
// and the entries after it are invalidated one by one. The ordered chain from
// the root is then rebuilt into the chain RAM, and the result carries the chain
// length and whether it changed. A read request returns one chain element. One
// request is in work at a time; a finished result waits in the output
// register while the next request is taken. Each removal and rebuild walk step
// reads the link of the current entry and uses the registered read data of the
// link RAM, which has one read port. No clearing pass is needed after reset.
module daisy_chain_topology_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dct_pkg::dct_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dct_pkg::dct_out_t out_data
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_OLD     = 9'b000000010,  // old link data back, write the new link
    S_DROP    = 9'b000000100,  // removal walk: check, invalidate, read link
    S_DROP_RD = 9'b000001000,  // removal walk: follow link
    S_BINIT   = 9'b000010000,  // start chain rebuild
    S_BUILD   = 9'b000100000,  // rebuild: check entry, read link
    S_BUILD_RD= 9'b001000000,  // rebuild: append next id
    S_READ    = 9'b010000000,  // chain RAM data back
    S_RESP    = 9'b100000000   // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  logic [dct_pkg::DEPTH-1:0]  valid_r, valid_nxt;
  logic [dct_pkg::DEPTH-1:0]  visited_r, visited_nxt;
  logic                       root_wr_r, root_wr_nxt;  // root link written once
  logic [dct_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [dct_pkg::CNT_W-1:0]  before_r, before_nxt;
  logic [dct_pkg::ID_W-1:0]   cur_r, cur_nxt;
  logic [dct_pkg::ID_W-1:0]   down_r, down_nxt;
  logic [dct_pkg::CIDX_W-1:0] idx_r, idx_nxt;
  logic                       op_r, op_nxt;
  logic [dct_pkg::ID_W-1:0]   rid_r, rid_nxt;
  logic                       rvld_r, rvld_nxt;
  logic                       out_valid_r, out_valid_nxt;
  dct_pkg::dct_out_t          out_r, out_nxt;

  // link RAM
  logic                       lt_we;
  logic [dct_pkg::IDX_W-1:0]  lt_waddr, lt_raddr;
  logic [dct_pkg::ID_W-1:0]   lt_wdata, lt_rdata;
  // chain RAM
  logic                       ch_we;
  logic [dct_pkg::IDX_W-1:0]  ch_waddr, ch_raddr;
  logic [dct_pkg::ID_W-1:0]   ch_wdata, ch_rdata;

  logic [dct_pkg::IDX_W-1:0]  cur_idx;
  logic                       cur_present;
  logic [dct_pkg::ID_W-1:0]   link;      // downstream of cur_r, read last cycle
  logic [dct_pkg::ID_W-1:0]   old_link;
  logic                       nxt_seen;
  logic                       in_acc;
  logic                       out_load;

  dct_ram #(.WIDTH(dct_pkg::ID_W), .DEPTH(dct_pkg::DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (lt_we),
    .waddr (lt_waddr),
    .wdata (lt_wdata),
    .raddr (lt_raddr),
    .rdata (lt_rdata)
  );

  dct_ram #(.WIDTH(dct_pkg::ID_W), .DEPTH(dct_pkg::DEPTH)) u_chain_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cur_idx     = cur_r[dct_pkg::IDX_W-1:0];
  assign cur_present = (int'(cur_r) < dct_pkg::DEPTH) && valid_r[cur_idx];
  // root link reads as unknown until the root first reports
  assign link = (cur_r == dct_pkg::ROOT_ID && !root_wr_r) ? dct_pkg::ID_NONE : lt_rdata;
  assign old_link = valid_r[cur_idx] ? link : dct_pkg::ID_NONE;
  assign nxt_seen = (int'(link) < dct_pkg::DEPTH) &&
                    visited_r[link[dct_pkg::IDX_W-1:0]];

  // RAM addressing: reads issue from IDLE (accepted request) or cur_r
  assign lt_raddr = (state_r == S_IDLE) ? in_data.module_id[dct_pkg::IDX_W-1:0] : cur_idx;
  assign lt_we    = (state_r == S_OLD);
  assign lt_waddr = cur_idx;
  assign lt_wdata = down_r;

  assign ch_raddr = in_data.chain_index[dct_pkg::IDX_W-1:0];
  assign ch_we    = (state_r == S_BUILD_RD) && (link != dct_pkg::ID_NONE) && !nxt_seen;
  assign ch_waddr = count_r[dct_pkg::IDX_W-1:0];
  assign ch_wdata = link;

  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    visited_nxt = visited_r;
    root_wr_nxt = root_wr_r;
    count_nxt   = count_r;
    before_nxt  = before_r;
    cur_nxt     = cur_r;
    down_nxt    = down_r;
    idx_nxt     = idx_r;
    op_nxt      = op_r;
    rid_nxt     = rid_r;
    rvld_nxt    = rvld_r;
    out_nxt     = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_data.operation;
          cur_nxt    = in_data.module_id;
          down_nxt   = in_data.downstream_id;
          idx_nxt    = in_data.chain_index;
          before_nxt = count_r;
          rid_nxt    = '0;
          rvld_nxt   = 1'b0;
          if (in_data.operation == dct_pkg::OP_READ) begin
            state_nxt = S_READ;
          end else if (int'(in_data.module_id) < dct_pkg::DEPTH) begin
            state_nxt = S_OLD;
          end else begin
            state_nxt = S_BINIT;  // out-of-table reporter: rebuild only
          end
        end
      end
      S_OLD: begin
        valid_nxt[cur_idx] = 1'b1;
        if (cur_r == dct_pkg::ROOT_ID) begin
          root_wr_nxt = 1'b1;
        end
        if (down_r == dct_pkg::ID_NONE && old_link != dct_pkg::ID_NONE) begin
          cur_nxt   = old_link;
          state_nxt = S_DROP;
        end else begin
          state_nxt = S_BINIT;
        end
      end
      S_DROP: begin
        if (cur_present) begin
          valid_nxt[cur_idx] = 1'b0;
          state_nxt = S_DROP_RD;
        end else begin
          state_nxt = S_BINIT;
        end
      end
      S_DROP_RD: begin
        cur_nxt   = link;
        state_nxt = S_DROP;
      end
      S_BINIT: begin
        visited_nxt = '0;
        visited_nxt[dct_pkg::ROOT_ID[dct_pkg::IDX_W-1:0]] = 1'b1;
        count_nxt = dct_pkg::CNT_W'(1);
        cur_nxt   = dct_pkg::ROOT_ID;
        state_nxt = S_BUILD;
      end
      S_BUILD: begin
        if (count_r >= dct_pkg::CNT_W'(dct_pkg::DEPTH) || !cur_present) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_BUILD_RD;
        end
      end
      S_BUILD_RD: begin
        if (ch_we) begin
          count_nxt = count_r + dct_pkg::CNT_W'(1);
          if (int'(link) < dct_pkg::DEPTH) begin
            visited_nxt[link[dct_pkg::IDX_W-1:0]] = 1'b1;
          end
          cur_nxt   = link;
          state_nxt = S_BUILD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_READ: begin
        // element 0 is always the root and is never stored
        if (idx_r == '0) begin
          rid_nxt  = dct_pkg::ROOT_ID;
          rvld_nxt = 1'b1;
        end else if (dct_pkg::CNT_W'(idx_r) < count_r) begin
          rid_nxt  = ch_rdata;
          rvld_nxt = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          out_nxt.chain_length   = count_r;
          out_nxt.length_changed = (op_r == dct_pkg::OP_REPORT) && (before_r != count_r);
          out_nxt.read_id        = rid_r;
          out_nxt.read_valid     = rvld_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      valid_r[dct_pkg::ROOT_ID[dct_pkg::IDX_W-1:0]] <= 1'b1;
      visited_r   <= '0;
      root_wr_r   <= 1'b0;
      count_r     <= dct_pkg::CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      visited_r   <= visited_nxt;
      root_wr_r   <= root_wr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    before_r <= before_nxt;
    cur_r    <= cur_nxt;
    down_r   <= down_nxt;
    idx_r    <= idx_nxt;
    op_r     <= op_nxt;
    rid_r    <= rid_nxt;
    rvld_r   <= rvld_nxt;
    out_r    <= out_nxt;
  end

  // chain length stays within 1..DEPTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= dct_pkg::CNT_W'(dct_pkg::DEPTH)))
    else $error("chain length out of range");

  // a removal step clears the entry it visits
  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DROP) && cur_present |=> !valid_r[$past(cur_idx)])
    else $error("removal step left entry valid");

  // no append past a full chain
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ch_we |-> (count_r < dct_pkg::CNT_W'(dct_pkg::DEPTH)))
    else $error("chain append beyond table depth");

  // the root is marked visited throughout the rebuild walk
  a_root_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUILD || state_r == S_BUILD_RD) |->
      visited_r[dct_pkg::ROOT_ID[dct_pkg::IDX_W-1:0]])
    else $error("root not visited during rebuild");

  // a report result never carries read data
  a_report_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (op_r == dct_pkg::OP_REPORT) |=> !out_r.read_valid && (out_r.read_id == '0))
    else $error("report result carries read data");

endmodule

/* sv/dct_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
